@@ src/midi_event_key_learn_decoder_unit_macros.svh @@
// Assertion helpers for the decoder RTL.
`ifndef MIDI_EVENT_KEY_LEARN_DECODER_UNIT_MACROS_SVH
`define MIDI_EVENT_KEY_LEARN_DECODER_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define MEKLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MEKLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mekld_pkg.sv @@
package mekld_pkg;

	// Key slots and their roles.
	localparam int unsigned KEY_SLOTS = 4;
	localparam int unsigned SLOT_W    = $clog2(KEY_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LEARN  = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_RUN    = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_FASTER = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] SLOT_SLOWER = SLOT_W'(3);
	localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(KEY_SLOTS - 1);

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_LEARN_KEY  = 3'd0;
	localparam logic [2:0] REG_RUN_KEY    = 3'd1;
	localparam logic [2:0] REG_FASTER_KEY = 3'd2;
	localparam logic [2:0] REG_SLOWER_KEY = 3'd3;
	localparam logic [2:0] REG_TEMPO      = 3'd4;

	// Status high nibbles.
	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_CONTROL  = 4'hb;
	localparam logic [3:0] ST_PROGRAM  = 4'hc;
	localparam logic [3:0] ST_BEND     = 4'he;
	localparam logic [3:0] ST_SYSTEM   = 4'hf;

	// Message classes reported with each result item.
	localparam logic [2:0] CLS_UNKNOWN  = 3'd0;
	localparam logic [2:0] CLS_SYSTEM   = 3'd1;
	localparam logic [2:0] CLS_NOTE_ON  = 3'd2;
	localparam logic [2:0] CLS_NOTE_OFF = 3'd3;
	localparam logic [2:0] CLS_CONTROL  = 3'd4;
	localparam logic [2:0] CLS_PROGRAM  = 3'd5;
	localparam logic [2:0] CLS_BEND     = 3'd6;

	// Controller numbers that carry the bank select.
	localparam logic [6:0] CC_BANK_MSB = 7'h00;
	localparam logic [6:0] CC_BANK_LSB = 7'h20;

	// Tempo limits and reset value.
	localparam logic [15:0] TEMPO_RESET = 16'd120;
	localparam logic [15:0] TEMPO_MAX   = 16'hffff;
	localparam logic [15:0] TEMPO_MIN   = 16'h0000;

	// Pitch bend scaling: percent = (v*200 - 100*16383) / 16383.
	localparam logic [7:0]  BEND_SCALE   = 8'd200;
	localparam logic [21:0] BEND_OFFSET  = 22'd1638300;
	localparam logic [14:0] BEND_DIVISOR = 15'd16383;

endpackage

@@ src/midi_event_key_learn_decoder_unit.sv @@
// MIDI event decoder with learned control keys. Each input item is one complete MIDI
// event; each produces exactly one result item with its class, channel nibble, the
// learn/run/tempo state after the event, the pitch bend percentage and the committed
// bank and program. An item is registered on entry and its result is registered on
// exit, so a new item is taken every cycle (one item per cycle sustained) as long as
// the result side keeps up; a stalled result holds the input register, which then
// stalls the input. Configuration writes load the key map and tempo at once and are
// expected only while the block is idle.
`include "midi_event_key_learn_decoder_unit_macros.svh"

module midi_event_key_learn_decoder_unit
	import mekld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  status_byte,
	input  logic [6:0]  first_data,
	input  logic [6:0]  second_data,
	input  logic        period_end,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  message_class,
	output logic [3:0]  channel_nibble,
	output logic        learning_now,
	output logic [1:0]  slot_now,
	output logic        running_now,
	output logic [15:0] tempo_now,
	output logic signed [7:0] bend_percent,
	output logic [13:0] bank_now,
	output logic [6:0]  program_now,
	output logic        patch_changed,
	output logic        keys_saved
);

	// Configuration registers and state.
	logic [6:0]        reg_key_q [KEY_SLOTS];
	logic [15:0]       reg_tempo_q;
	logic [6:0]        key_map_q [KEY_SLOTS];
	logic              learn_mode_q;
	logic [SLOT_W-1:0] learn_slot_q;
	logic              run_flag_q;
	logic [15:0]       tempo_bpm_q;
	logic [6:0]        bank_lsb_q;
	logic [13:0]       pending_bank_q;
	logic [6:0]        pending_program_q;
	logic [13:0]       current_bank_q;
	logic [6:0]        current_program_q;

	// Input register.
	logic        valid_s1;
	logic [7:0]  status_s1;
	logic [6:0]  first_s1;
	logic [6:0]  second_s1;
	logic        pend_s1;

	// Result register.
	logic              result_valid_q;
	logic [2:0]        message_class_q;
	logic [3:0]        channel_nibble_q;
	logic              learning_now_q;
	logic [SLOT_W-1:0] slot_now_q;
	logic              running_now_q;
	logic [15:0]       tempo_now_q;
	logic [7:0]        bend_percent_q;
	logic [13:0]       bank_now_q;
	logic [6:0]        program_now_q;
	logic              patch_changed_q;
	logic              keys_saved_q;

	logic       advance;
	logic       cfg_we;
	logic [2:0] cfg_idx;

	// Next-state values for the item in the input register.
	logic [2:0]        cls_nx;
	logic [6:0]        key_map_nx [KEY_SLOTS];
	logic              learn_mode_nx;
	logic [SLOT_W-1:0] learn_slot_nx;
	logic              run_flag_nx;
	logic [15:0]       tempo_nx;
	logic [6:0]        bank_lsb_nx;
	logic [13:0]       pend_bank_ev;
	logic [6:0]        pend_prog_ev;
	logic [13:0]       pending_bank_nx;
	logic [6:0]        pending_program_nx;
	logic [13:0]       current_bank_nx;
	logic [6:0]        current_program_nx;
	logic              changed_nx;
	logic              saved_nx;
	logic [7:0]        bend_nx;

	// Bend arithmetic.
	logic [13:0] bend_v;
	logic [21:0] bend_scaled;
	logic        bend_neg;
	logic [20:0] bend_mag;
	logic [6:0]  bend_q0;
	logic [14:0] bend_rem;
	logic [6:0]  bend_quot;

	// Handshake: the input register moves on whenever the result register is free or drained.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = 32'd0;
		unique case (cfg_idx)
			REG_LEARN_KEY:  prdata = {25'd0, reg_key_q[SLOT_LEARN]};
			REG_RUN_KEY:    prdata = {25'd0, reg_key_q[SLOT_RUN]};
			REG_FASTER_KEY: prdata = {25'd0, reg_key_q[SLOT_FASTER]};
			REG_SLOWER_KEY: prdata = {25'd0, reg_key_q[SLOT_SLOWER]};
			REG_TEMPO:      prdata = {16'd0, reg_tempo_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Pitch bend as a percentage; the divide by 16383 uses 16383 = 2^14 - 1.
	always_comb begin
		bend_v      = {second_s1, first_s1};
		bend_scaled = 22'(bend_v) * 22'(BEND_SCALE);
		bend_neg    = bend_scaled < BEND_OFFSET;
		bend_mag    = bend_neg ? 21'(BEND_OFFSET - bend_scaled)
		                       : 21'(bend_scaled - BEND_OFFSET);
		bend_q0     = bend_mag[20:14];
		bend_rem    = {1'b0, bend_mag[13:0]} + {8'd0, bend_q0};
		bend_quot   = bend_q0 + {6'd0, bend_rem >= BEND_DIVISOR};
	end

	// Event decode and state update.
	always_comb begin
		cls_nx        = CLS_UNKNOWN;
		key_map_nx    = key_map_q;
		learn_mode_nx = learn_mode_q;
		learn_slot_nx = learn_slot_q;
		run_flag_nx   = run_flag_q;
		tempo_nx      = tempo_bpm_q;
		bank_lsb_nx   = bank_lsb_q;
		pend_bank_ev  = pending_bank_q;
		pend_prog_ev  = pending_program_q;
		saved_nx      = 1'b0;
		bend_nx       = 8'd0;

		unique case (status_s1[7:4])
			ST_SYSTEM:  cls_nx = CLS_SYSTEM;
			ST_NOTE_ON: cls_nx = CLS_NOTE_ON;
			ST_NOTE_OFF: begin
				cls_nx = CLS_NOTE_OFF;
				if (learn_mode_q) begin
					if (first_s1 == key_map_q[SLOT_LEARN]) begin
						if (learn_slot_q == SLOT_LAST) begin
							learn_slot_nx = SLOT_LEARN;
							learn_mode_nx = 1'b0;
							saved_nx      = 1'b1;
						end else begin
							learn_slot_nx = learn_slot_q + SLOT_W'(1);
						end
					end else begin
						key_map_nx[learn_slot_q] = first_s1;
					end
				end else if (first_s1 == key_map_q[SLOT_LEARN]) begin
					learn_mode_nx = 1'b1;
				end else if (first_s1 == key_map_q[SLOT_RUN]) begin
					run_flag_nx = !run_flag_q;
				end else if (first_s1 == key_map_q[SLOT_FASTER]) begin
					if (tempo_bpm_q != TEMPO_MAX) tempo_nx = tempo_bpm_q + 16'd1;
				end else if (first_s1 == key_map_q[SLOT_SLOWER]) begin
					if (tempo_bpm_q != TEMPO_MIN) tempo_nx = tempo_bpm_q - 16'd1;
				end
			end
			ST_CONTROL: begin
				cls_nx = CLS_CONTROL;
				if (first_s1 == CC_BANK_MSB) begin
					pend_bank_ev = {second_s1, bank_lsb_q};
				end else if (first_s1 == CC_BANK_LSB) begin
					bank_lsb_nx = second_s1;
				end
			end
			ST_PROGRAM: begin
				cls_nx       = CLS_PROGRAM;
				pend_prog_ev = first_s1;
			end
			ST_BEND: begin
				cls_nx  = CLS_BEND;
				bend_nx = bend_neg ? 8'(-{1'b0, bend_quot}) : {1'b0, bend_quot};
			end
			default: cls_nx = CLS_UNKNOWN;
		endcase

		// Period end commits the pending patch when it differs.
		current_bank_nx    = current_bank_q;
		current_program_nx = current_program_q;
		changed_nx         = 1'b0;
		pending_bank_nx    = pend_bank_ev;
		pending_program_nx = pend_prog_ev;
		if (pend_s1) begin
			if (pend_bank_ev != current_bank_q || pend_prog_ev != current_program_q) begin
				current_bank_nx    = pend_bank_ev;
				current_program_nx = pend_prog_ev;
				changed_nx         = 1'b1;
			end
			pending_bank_nx    = current_bank_nx;
			pending_program_nx = current_program_nx;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			status_s1 <= status_byte;
			first_s1  <= first_data;
			second_s1 <= second_data;
			pend_s1   <= period_end;
		end
	end

	// State and configuration registers; the user must write a register only while idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				reg_key_q[i] <= 7'd0;
				key_map_q[i] <= 7'd0;
			end
			reg_tempo_q       <= TEMPO_RESET;
			tempo_bpm_q       <= TEMPO_RESET;
			learn_mode_q      <= 1'b0;
			learn_slot_q      <= SLOT_LEARN;
			run_flag_q        <= 1'b0;
			bank_lsb_q        <= 7'd0;
			pending_bank_q    <= 14'd0;
			pending_program_q <= 7'd0;
			current_bank_q    <= 14'd0;
			current_program_q <= 7'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx) inside
					REG_LEARN_KEY, REG_RUN_KEY, REG_FASTER_KEY, REG_SLOWER_KEY: begin
						reg_key_q[cfg_idx[SLOT_W-1:0]] <= pwdata[6:0];
						key_map_q[cfg_idx[SLOT_W-1:0]] <= pwdata[6:0];
					end
					REG_TEMPO: begin
						reg_tempo_q <= pwdata[15:0];
						tempo_bpm_q <= pwdata[15:0];
					end
					default: ;
				endcase
			end else if (advance) begin
				key_map_q         <= key_map_nx;
				learn_mode_q      <= learn_mode_nx;
				learn_slot_q      <= learn_slot_nx;
				run_flag_q        <= run_flag_nx;
				tempo_bpm_q       <= tempo_nx;
				bank_lsb_q        <= bank_lsb_nx;
				pending_bank_q    <= pending_bank_nx;
				pending_program_q <= pending_program_nx;
				current_bank_q    <= current_bank_nx;
				current_program_q <= current_program_nx;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			message_class_q  <= cls_nx;
			channel_nibble_q <= status_s1[3:0];
			learning_now_q   <= learn_mode_nx;
			slot_now_q       <= learn_slot_nx;
			running_now_q    <= run_flag_nx;
			tempo_now_q      <= tempo_nx;
			bend_percent_q   <= bend_nx;
			bank_now_q       <= current_bank_nx;
			program_now_q    <= current_program_nx;
			patch_changed_q  <= changed_nx;
			keys_saved_q     <= saved_nx;
		end
	end

	assign result_valid   = result_valid_q;
	assign message_class  = message_class_q;
	assign channel_nibble = channel_nibble_q;
	assign learning_now   = learning_now_q;
	assign slot_now       = slot_now_q;
	assign running_now    = running_now_q;
	assign tempo_now      = tempo_now_q;
	assign bend_percent   = bend_percent_q;
	assign bank_now       = bank_now_q;
	assign program_now    = program_now_q;
	assign patch_changed  = patch_changed_q;
	assign keys_saved     = keys_saved_q;

	// A slot other than the learn slot is only ever selected during learn mode.
	`MEKLD_ASSERT(a_slot_needs_learn, (learn_slot_q != SLOT_LEARN) |-> learn_mode_q, "learn slot set outside learn mode")
	// Completing the key map leaves learn mode at the first slot.
	`MEKLD_ASSERT(a_saved_exits_learn, (result_valid_q && keys_saved_q) |-> (!learning_now_q && slot_now_q == SLOT_LEARN), "save pulse without leaving learn mode")
	// Only a bend event carries a nonzero percentage.
	`MEKLD_ASSERT(a_bend_only_on_bend, (result_valid_q && bend_percent_q != 8'd0) |-> (message_class_q == CLS_BEND), "bend percent on a non-bend item")
	// An item that leaves the input register shows up as a result in the next cycle.
	`MEKLD_ASSERT(a_advance_gives_result, advance |=> result_valid_q, "advanced item lost")
	// The input stalls only while an item sits in the input register.
	`MEKLD_ASSERT_ALWAYS(a_stall_needs_item, item_stall |-> valid_s1, "input stalled while empty")

endmodule
